/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/bcsh_pkg.sv */
// ----------------------------------------------------------------------------
// bcsh_pkg
// Constants, codes and controller/datapath interface types of the histogram.
// ----------------------------------------------------------------------------
package bcsh_pkg;

  localparam int NUM_BINS        = 120;
  localparam int SLOTS_PER_GROUP = 8;
  localparam int NUM_CELLS       = NUM_BINS * SLOTS_PER_GROUP;

  localparam int BIN_W   = 7;
  localparam int SLOT_W  = 3;
  localparam int CELL_AW = BIN_W + SLOT_W;
  localparam int CLR_W   = $clog2(NUM_CELLS + 1);
  localparam int CNT_W   = 64;
  localparam int REC_W   = 32;
  localparam int CHN_W   = 24;
  localparam int GRP_W   = 2;

  // Readout runs over three groups of slots and then the bin total.
  localparam int READ_ITEMS = 3 * SLOTS_PER_GROUP + 1;
  localparam int IDX_W      = $clog2(READ_ITEMS);

  // Opcodes.
  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Counter group codes.
  localparam logic [GRP_W-1:0] GRP_A     = 2'd0;
  localparam logic [GRP_W-1:0] GRP_B     = 2'd1;
  localparam logic [GRP_W-1:0] GRP_C     = 2'd2;
  localparam logic [GRP_W-1:0] GRP_TOTAL = 2'd3;

  // Header record marker.
  localparam logic [REC_W-1:0] HEADER_RECORD  = 32'd1;
  localparam logic [CHN_W-1:0] HEADER_CHANNEL = 24'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic acc_write;
    logic idx_next;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic skip;
    logic is_read;
    logic read_last;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/bcsh_ctrl.sv */
// ----------------------------------------------------------------------------
// bcsh_ctrl
// Controller state machine: clearing pass, request intake, accumulate write
// and readout sequencing.
// ----------------------------------------------------------------------------
module bcsh_ctrl
  import bcsh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DECODE  = 3'd2;
  localparam logic [2:0] S_ACC_WR  = 3'd3;
  localparam logic [2:0] S_RD_ADDR = 3'd4;
  localparam logic [2:0] S_RD_DATA = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        // The memories are read from the latched request during this cycle.
        if (status_i.skip) begin
          state_d = S_IDLE;
        end else if (status_i.is_read) begin
          state_d = S_RD_DATA;
        end else begin
          state_d = S_ACC_WR;
        end
      end
      S_ACC_WR: begin
        cmd_o.acc_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_RD_ADDR: begin
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.read_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_next = 1'b1;
            state_d        = S_RD_ADDR;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/bcsh_datapath.sv */
// ----------------------------------------------------------------------------
// bcsh_datapath
// Counter memories, request registers, read-modify-write adders and the
// output register of the histogram.
// ----------------------------------------------------------------------------
module bcsh_datapath
  import bcsh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  logic               opcode_i,
  input  logic [REC_W-1:0]   record_number_i,
  input  logic [CHN_W-1:0]   channel_word_i,
  input  logic [CNT_W-1:0]   count_value_i,
  input  logic [BIN_W-1:0]   read_bin_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BIN_W-1:0]   bin_index_o,
  output logic [GRP_W-1:0]   counter_group_o,
  output logic [SLOT_W-1:0]  counter_slot_o,
  output logic [CNT_W-1:0]   counter_value_o,
  output logic               last_o
);

  // Counter stores.
  logic [CNT_W-1:0] mem_a [0:NUM_CELLS-1];
  logic [CNT_W-1:0] mem_b [0:NUM_CELLS-1];
  logic [CNT_W-1:0] mem_c [0:NUM_CELLS-1];
  logic [CNT_W-1:0] mem_t [0:NUM_BINS-1];

  logic [CNT_W-1:0]   rd_a_q, rd_b_q, rd_c_q, rd_t_q;
  logic [CLR_W-1:0]   clr_q;
  logic [IDX_W-1:0]   idx_q;
  logic               is_read_q, skip_q;
  logic [BIN_W-1:0]   bin_q;
  logic [SLOT_W-1:0]  sa_q, sb_q, sc_q;
  logic [CNT_W-1:0]   count_q;
  logic               out_valid_q;
  logic [BIN_W-1:0]   out_bin_q;
  logic [GRP_W-1:0]   out_grp_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [CNT_W-1:0]   out_value_q;
  logic               out_last_q;

  logic [BIN_W-1:0]   bin_d;
  logic               skip_d;
  logic               header;
  logic [GRP_W-1:0]   rd_grp;
  logic [SLOT_W-1:0]  rd_slot;
  logic [CELL_AW-1:0] addr_a, addr_b, addr_c, clr_addr;
  logic [BIN_W-1:0]   clr_bin;
  logic               clr_tot;
  logic [CNT_W-1:0]   rd_value;

  // Request decode at intake.
  always_comb begin
    header = (record_number_i == HEADER_RECORD) && (channel_word_i == HEADER_CHANNEL);
    if (opcode_i == OP_READ) begin
      bin_d  = read_bin_i;
      skip_d = {1'b0, read_bin_i} >= (BIN_W + 1)'(NUM_BINS);
    end else begin
      bin_d  = channel_word_i[23:17];
      skip_d = header || ({1'b0, channel_word_i[23:17]} >= (BIN_W + 1)'(NUM_BINS));
    end
  end

  // Request registers and readout index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_read_q <= (opcode_i == OP_READ);
      skip_q    <= skip_d;
      bin_q     <= bin_d;
      sa_q      <= channel_word_i[16:14];
      sb_q      <= channel_word_i[11:9];
      sc_q      <= channel_word_i[2:0];
      count_q   <= count_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.idx_next) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + CLR_W'(1);
      end
    end
  end

  // Readout position: groups of eight slots, then the total.
  assign rd_grp  = idx_q[IDX_W-1:SLOT_W];
  assign rd_slot = idx_q[SLOT_W-1:0];

  // Memory addresses: the clearing pass, the readout slot or the record's slots.
  always_comb begin
    clr_addr = clr_q[CELL_AW-1:0];
    clr_bin  = clr_q[BIN_W-1:0];
    clr_tot  = clr_q < CLR_W'(NUM_BINS);
    if (is_read_q) begin
      addr_a = {bin_q, rd_slot};
      addr_b = {bin_q, rd_slot};
      addr_c = {bin_q, rd_slot};
    end else begin
      addr_a = {bin_q, sa_q};
      addr_b = {bin_q, sb_q};
      addr_c = {bin_q, sc_q};
    end
  end

  // Group A store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_a[clr_addr] <= '0;
    end else if (cmd_i.acc_write) begin
      mem_a[addr_a] <= rd_a_q + count_q;
    end
    rd_a_q <= mem_a[addr_a];
  end

  // Group B store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_b[clr_addr] <= '0;
    end else if (cmd_i.acc_write) begin
      mem_b[addr_b] <= rd_b_q + count_q;
    end
    rd_b_q <= mem_b[addr_b];
  end

  // Group C store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_c[clr_addr] <= '0;
    end else if (cmd_i.acc_write) begin
      mem_c[addr_c] <= rd_c_q + count_q;
    end
    rd_c_q <= mem_c[addr_c];
  end

  // Bin totals store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (clr_tot) begin
        mem_t[clr_bin] <= '0;
      end
    end else if (cmd_i.acc_write) begin
      mem_t[bin_q] <= rd_t_q + count_q;
    end
    rd_t_q <= mem_t[bin_q];
  end

  // Select the counter being reported.
  always_comb begin
    case (rd_grp)
      GRP_A:   rd_value = rd_a_q;
      GRP_B:   rd_value = rd_b_q;
      GRP_C:   rd_value = rd_c_q;
      default: rd_value = rd_t_q;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_bin_q   <= bin_q;
      out_grp_q   <= rd_grp;
      out_slot_q  <= rd_slot;
      out_value_q <= rd_value;
      out_last_q  <= (rd_grp == GRP_TOTAL);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bin_index_o     = out_bin_q;
  assign counter_group_o = out_grp_q;
  assign counter_slot_o  = out_slot_q;
  assign counter_value_o = out_value_q;
  assign last_o          = out_last_q;

  // Status towards the controller.
  always_comb begin
    status_o.clear_last = (clr_q == CLR_W'(NUM_CELLS - 1));
    status_o.skip       = skip_q;
    status_o.is_read    = is_read_q;
    status_o.read_last  = (rd_grp == GRP_TOTAL);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

/* hdl/bunch_crossing_scaler_histogram.sv */
// ----------------------------------------------------------------------------
// bunch_crossing_scaler_histogram
// Top level: accumulates scaler records into per-bin counter histograms and
// reads out one bin's 25 counters on request.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the counter
// memories and holds in_ready_o low until it is done. An accumulate request
// then passes through intake, memory read, and add and write back through the
// single port of each counter memory; header records and out-of-range bins
// are dropped after the decode state. A readout steps through a data state and
// an address state for each of its 25 counters, with a registered memory read
// preceding each result, and waits while the output side stalls. Results leave
// through an output register, so the next request is taken while the last result still waits.
module bunch_crossing_scaler_histogram
  import bcsh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [REC_W-1:0]   record_number_i,
  input  logic [CHN_W-1:0]   channel_word_i,
  input  logic [CNT_W-1:0]   count_value_i,
  input  logic [BIN_W-1:0]   read_bin_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BIN_W-1:0]   bin_index_o,
  output logic [GRP_W-1:0]   counter_group_o,
  output logic [SLOT_W-1:0]  counter_slot_o,
  output logic [CNT_W-1:0]   counter_value_o,
  output logic               last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing.
  bcsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  bcsh_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (opcode_i),
    .record_number_i (record_number_i),
    .channel_word_i  (channel_word_i),
    .count_value_i   (count_value_i),
    .read_bin_i      (read_bin_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bin_index_o     (bin_index_o),
    .counter_group_o (counter_group_o),
    .counter_slot_o  (counter_slot_o),
    .counter_value_o (counter_value_o),
    .last_o          (last_o)
  );

endmodule

/* hdl/bcsh_checker.sv */
// ----------------------------------------------------------------------------
// bcsh_checker
// Port-level checks of the histogram, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcsh_checker
  import bcsh_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               opcode_i,
  input logic [REC_W-1:0]   record_number_i,
  input logic [CHN_W-1:0]   channel_word_i,
  input logic [CNT_W-1:0]   count_value_i,
  input logic [BIN_W-1:0]   read_bin_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [BIN_W-1:0]   bin_index_o,
  input logic [GRP_W-1:0]   counter_group_o,
  input logic [SLOT_W-1:0]  counter_slot_o,
  input logic [CNT_W-1:0]   counter_value_o,
  input logic               last_o
);

  logic last_is_total;
  logic bin_in_range;

  // Conditions on the offered result.
  assign last_is_total = (counter_group_o == GRP_TOTAL) && (counter_slot_o == '0);
  assign bin_in_range  = {1'b0, bin_index_o} < (BIN_W + 1)'(NUM_BINS);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // The block works on one request at a time.
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // The final result of a readout is the bin total.
  `ASSERT_IMPLY(a_last_total, clk_i, rst_ni, out_valid_o && last_o, last_is_total)

  // Only bins in range are ever reported.
  `ASSERT_IMPLY(a_bin_range, clk_i, rst_ni, out_valid_o, bin_in_range)

endmodule

bind bunch_crossing_scaler_histogram bcsh_checker u_bcsh_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for bunch_crossing_scaler_histogram. A driver sends
// accumulate and readout requests from a queue. A predictor keeps its own copy
// of the counter histograms and lists the counters that each readout should
// return. A monitor compares every result with the oldest listed counter.
// ----------------------------------------------------------------------------
module tb
  import bcsh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_COUNT = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;

  // One request as the driver presents it.
  typedef struct {
    logic              opcode;
    logic [REC_W-1:0]  record_number;
    logic [CHN_W-1:0]  channel_word;
    logic [CNT_W-1:0]  count_value;
    logic [BIN_W-1:0]  read_bin;
  } scaler_request_t;

  // One counter as the readout should report it.
  typedef struct {
    logic [BIN_W-1:0]  bin;
    logic [GRP_W-1:0]  group;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  value;
    logic              last;
  } counter_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               opcode_i = OP_ACC;
  logic [REC_W-1:0]   record_number_i = '0;
  logic [CHN_W-1:0]   channel_word_i = '0;
  logic [CNT_W-1:0]   count_value_i = '0;
  logic [BIN_W-1:0]   read_bin_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [BIN_W-1:0]   bin_index_o;
  logic [GRP_W-1:0]   counter_group_o;
  logic [SLOT_W-1:0]  counter_slot_o;
  logic [CNT_W-1:0]   counter_value_o;
  logic               last_o;

  // Shadow copy of the histograms, cleared as after reset.
  logic [CNT_W-1:0]   shadow_a [NUM_CELLS];
  logic [CNT_W-1:0]   shadow_b [NUM_CELLS];
  logic [CNT_W-1:0]   shadow_c [NUM_CELLS];
  logic [CNT_W-1:0]   shadow_total [NUM_BINS];

  scaler_request_t    request_q [$];
  counter_report_t    expected_reports_q [$];
  scaler_request_t    held_request;

  logic [BIN_W-1:0]   hot_bins [6] = '{7'd0, 7'd1, 7'd2, 7'd59, 7'd118, 7'd119};

  int total_requests;
  int accepted_count;
  int ignored_count;
  int readout_count;
  int checked_count;
  int error_count;
  int cycle_count;
  int send_idle_pct = 7;
  int recv_idle_pct = 60;

  bunch_crossing_scaler_histogram u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .record_number_i (record_number_i),
    .channel_word_i  (channel_word_i),
    .count_value_i   (count_value_i),
    .read_bin_i      (read_bin_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bin_index_o     (bin_index_o),
    .counter_group_o (counter_group_o),
    .counter_slot_o  (counter_slot_o),
    .counter_value_o (counter_value_o),
    .last_o          (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Packs a bin and three slot selections into a channel word; the spare bits
  // fill the unused positions 12-13 and 3-8.
  function automatic logic [CHN_W-1:0] chan_word(input logic [BIN_W-1:0] bin,
                                                 input logic [2:0] sa,
                                                 input logic [2:0] sb,
                                                 input logic [2:0] sc,
                                                 input logic [7:0] spare);
    return {bin, sa, spare[7:6], sb, spare[5:0], sc};
  endfunction

  function automatic scaler_request_t acc_request(input logic [REC_W-1:0] rec,
                                                  input logic [CHN_W-1:0] chn,
                                                  input logic [CNT_W-1:0] cnt);
    scaler_request_t rq;
    rq.opcode        = OP_ACC;
    rq.record_number = rec;
    rq.channel_word  = chn;
    rq.count_value   = cnt;
    rq.read_bin      = BIN_W'($urandom_range(127));
    return rq;
  endfunction

  // Unused fields of a readout carry random junk.
  function automatic scaler_request_t read_request(input logic [BIN_W-1:0] bin);
    scaler_request_t rq;
    rq.opcode        = OP_READ;
    rq.record_number = $urandom;
    rq.channel_word  = CHN_W'($urandom);
    rq.count_value   = {$urandom, $urandom};
    rq.read_bin      = bin;
    return rq;
  endfunction

  function automatic logic [CNT_W-1:0] random_count();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return CNT_W'($urandom_range(1000));
    else if (pick < 8) return {$urandom, $urandom};
    else return 64'hFFFF_FFFF_FFFF_FFFF - CNT_W'($urandom_range(15));
  endfunction

  task automatic push_counter(input logic [BIN_W-1:0] bin, input logic [GRP_W-1:0] group,
                              input int slot, input logic [CNT_W-1:0] value,
                              input logic last);
    counter_report_t rep;
    rep.bin   = bin;
    rep.group = group;
    rep.slot  = SLOT_W'(slot);
    rep.value = value;
    rep.last  = last;
    expected_reports_q.push_back(rep);
  endtask

  // Histogram predictor: updates the shadow counters for an accumulate and
  // lists the 25 counters that a readout of an existing bin returns.
  task automatic histogram_apply(input scaler_request_t rq);
    logic [BIN_W-1:0] bin;
    int               base;
    if (rq.opcode == OP_ACC) begin
      bin = rq.channel_word[23:17];
      if ((rq.record_number == HEADER_RECORD && rq.channel_word == HEADER_CHANNEL) ||
          bin >= NUM_BINS) begin
        ignored_count++;
      end else begin
        base = bin * SLOTS_PER_GROUP;
        shadow_a[base + rq.channel_word[16:14]] += rq.count_value;
        shadow_b[base + rq.channel_word[11:9]]  += rq.count_value;
        shadow_c[base + rq.channel_word[2:0]]   += rq.count_value;
        shadow_total[bin] += rq.count_value;
      end
    end else begin
      bin = rq.read_bin;
      if (bin >= NUM_BINS) begin
        ignored_count++;
      end else begin
        base = bin * SLOTS_PER_GROUP;
        readout_count++;
        for (int s = 0; s < SLOTS_PER_GROUP; s++)
          push_counter(bin, GRP_A, s, shadow_a[base + s], 1'b0);
        for (int s = 0; s < SLOTS_PER_GROUP; s++)
          push_counter(bin, GRP_B, s, shadow_b[base + s], 1'b0);
        for (int s = 0; s < SLOTS_PER_GROUP; s++)
          push_counter(bin, GRP_C, s, shadow_c[base + s], 1'b0);
        push_counter(bin, GRP_TOTAL, 0, shadow_total[bin], 1'b1);
      end
    end
  endtask

  // Driver: predicts each accepted request and presents the next one, with
  // random gaps that follow the current idling phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        histogram_apply(held_request);
        accepted_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_request     = request_q.pop_front();
          opcode_i        <= held_request.opcode;
          record_number_i <= held_request.record_number;
          channel_word_i  <= held_request.channel_word;
          count_value_i   <= held_request.count_value;
          read_bin_i      <= held_request.read_bin;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // Idling phases: slow receiver, then slow sender, then full rate.
      if (accepted_count < total_requests / 3) begin
        send_idle_pct <= 7;
        recv_idle_pct <= 60;
      end else if (accepted_count < (2 * total_requests) / 3) begin
        send_idle_pct <= 60;
        recv_idle_pct <= 7;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expected counter.
  always @(posedge clk_i or negedge rst_ni) begin
    counter_report_t exp_rep;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("tb: unexpected result bin %0d group %0d slot %0d value %h last %b",
                     bin_index_o, counter_group_o, counter_slot_o, counter_value_o, last_o);
        end else begin
          exp_rep = expected_reports_q.pop_front();
          checked_count++;
          if (bin_index_o !== exp_rep.bin || counter_group_o !== exp_rep.group ||
              counter_slot_o !== exp_rep.slot || counter_value_o !== exp_rep.value ||
              last_o !== exp_rep.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("tb: mismatch exp %0d %0d %0d %h %b, got %0d %0d %0d %h %b",
                       exp_rep.bin, exp_rep.group, exp_rep.slot, exp_rep.value, exp_rep.last,
                       bin_index_o, counter_group_o, counter_slot_o, counter_value_o, last_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog over the whole run, including the clearing pass after reset.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int               effective;
    int               pick;
    logic [BIN_W-1:0] bin;
    logic [7:0]       spare;

    for (int i = 0; i < NUM_CELLS; i++) begin
      shadow_a[i] = '0;
      shadow_b[i] = '0;
      shadow_c[i] = '0;
    end
    for (int i = 0; i < NUM_BINS; i++) shadow_total[i] = '0;

    // Directed requests: cleared counters, header and near-header records,
    // wrap-around, ignored channel bits and bins out of range.
    request_q.push_back(read_request(7'd0));
    request_q.push_back(read_request(7'd119));
    request_q.push_back(acc_request(32'd0, 24'd0, 64'd1));
    request_q.push_back(acc_request(HEADER_RECORD, HEADER_CHANNEL, 64'hFFFF_FFFF_FFFF_FFFF));
    request_q.push_back(acc_request(HEADER_RECORD, chan_word(7'd0, 3'd7, 3'd7, 3'd7, 8'hFF),
                                    64'hFFFF_FFFF_FFFF_FFFF));
    request_q.push_back(acc_request(32'hFFFF_FFFF, chan_word(7'd0, 3'd7, 3'd7, 3'd7, 8'h00),
                                    64'd2));
    request_q.push_back(acc_request(32'd2, chan_word(7'd119, 3'd3, 3'd5, 3'd1, 8'hA5),
                                    64'h8000_0000_0000_0000));
    request_q.push_back(acc_request(32'd3, chan_word(7'd119, 3'd3, 3'd5, 3'd1, 8'h5A),
                                    64'h8000_0000_0000_0000));
    request_q.push_back(acc_request(32'd4, chan_word(7'd119, 3'd3, 3'd0, 3'd6, 8'h00), 64'd5));
    request_q.push_back(acc_request(32'd5, chan_word(7'd120, 3'd1, 3'd1, 3'd1, 8'h00), 64'd9));
    request_q.push_back(acc_request(32'd6, 24'hFFFFFF, 64'd9));
    request_q.push_back(acc_request(32'h8000_0000, chan_word(7'd119, 3'd7, 3'd7, 3'd7, 8'hFF),
                                    64'hFFFF_FFFF_FFFF_FFFF));
    request_q.push_back(acc_request(32'd7, chan_word(7'd1, 3'd0, 3'd4, 3'd2, 8'hC3),
                                    64'h0123_4567_89AB_CDEF));
    request_q.push_back(read_request(7'd0));
    request_q.push_back(read_request(7'd119));
    request_q.push_back(read_request(7'd120));
    request_q.push_back(read_request(7'd127));
    request_q.push_back(read_request(7'd1));
    request_q.push_back(read_request(7'd2));

    // Random requests, mostly accumulates into a few busy bins so that
    // readouts see real sums, with some noise that the block must skip.
    effective = 0;
    while (effective < RANDOM_COUNT) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        if ($urandom_range(9) < 8) bin = hot_bins[$urandom_range(5)];
        else bin = BIN_W'($urandom_range(127));
        request_q.push_back(read_request(bin));
        if (bin < NUM_BINS) effective++;
      end else if (pick < 16) begin
        if ($urandom_range(1) == 0)
          request_q.push_back(acc_request(HEADER_RECORD, HEADER_CHANNEL, random_count()));
        else
          request_q.push_back(acc_request($urandom,
                                          chan_word(BIN_W'($urandom_range(127, NUM_BINS)),
                                                    3'($urandom), 3'($urandom), 3'($urandom),
                                                    8'($urandom)),
                                          random_count()));
      end else begin
        if ($urandom_range(3) != 0) bin = hot_bins[$urandom_range(5)];
        else bin = BIN_W'($urandom_range(NUM_BINS - 1));
        spare = 8'($urandom);
        request_q.push_back(acc_request($urandom,
                                        chan_word(bin, 3'($urandom), 3'($urandom),
                                                  3'($urandom), spare),
                                        random_count()));
        effective++;
      end
    end
    // Final readout of every busy bin.
    for (int i = 0; i < 6; i++) request_q.push_back(read_request(hot_bins[i]));
    total_requests = request_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and every result to be checked.
    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_reports_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_reports_q.size() != 0) begin
      error_count++;
      $display("tb: %0d expected results never arrived", expected_reports_q.size());
    end
    $display("tb: %0d requests taken, %0d of them skipped by the block, %0d readouts",
             accepted_count, ignored_count, readout_count);
    $display("tb: %0d counter results checked, %0d mismatches", checked_count, error_count);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/bcsh_pkg.sv
hdl/bcsh_ctrl.sv
hdl/bcsh_datapath.sv
hdl/bunch_crossing_scaler_histogram.sv
hdl/bcsh_checker.sv
tb/tb.sv
